// ===== rtl/bpa_pkg.sv =====
// Shared constants, types and helper functions for the bitmap page allocator.
`default_nettype none
package bpa_pkg;

    localparam int MAX_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 11;
    localparam int WORD_BITS = 32;
    localparam int WORDS     = MAX_PAGES / WORD_BITS;
    localparam int WORD_AW   = $clog2(WORDS);
    localparam int BIT_AW    = $clog2(WORD_BITS);
    localparam int IDX_W     = $clog2(MAX_PAGES);
    localparam int PIDX_W    = ADDR_W - PAGE_SHIFT;
    localparam int PN_W      = CNT_W + 1;

    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_PAGES);
    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [1:0] CFG_BASE     = 2'd0;
    localparam logic [1:0] CFG_MANAGED  = 2'd1;
    localparam logic [1:0] CFG_OFFSET   = 2'd2;
    localparam logic [1:0] CFG_RESERVED = 2'd3;

    // Map port commands from the sequencer.
    typedef struct packed {
        logic               rd_en;
        logic [WORD_AW-1:0] rd_addr;
        logic               wr_en;
        logic [WORD_AW-1:0] wr_addr;
    } map_cmd_t;

    // Bits of word w whose page index lies below bound.
    function automatic logic [WORD_BITS-1:0] prefix_mask(
        input logic [CNT_W-1:0]   bound,
        input logic [WORD_AW-1:0] w
    );
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] rem;
        logic [WORD_BITS-1:0] m;
        base = CNT_W'({w, {BIT_AW{1'b0}}});
        rem  = bound - base;
        if (bound <= base)
            m = '0;
        else if (rem >= CNT_W'(WORD_BITS))
            m = '1;
        else
            m = ~({WORD_BITS{1'b1}} << rem[BIT_AW-1:0]);
        return m;
    endfunction

    // Position of the lowest set bit.
    function automatic logic [BIT_AW-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_AW-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i])
                pos = BIT_AW'(i);
        end
        return pos;
    endfunction

    function automatic logic [ADDR_W-1:0] align_up(input logic [ADDR_W-1:0] a);
        return (a + PAGE_MASK) & ~PAGE_MASK;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bpa_map.sv =====
// Used-bit map storage: word memory with per-row valid flags cleared at reset.
`default_nettype none
module bpa_map (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bpa_pkg::map_cmd_t               cmd,
    input  wire logic [bpa_pkg::WORD_BITS-1:0]   wr_data,
    output logic      [bpa_pkg::WORD_BITS-1:0]   rd_data
);
    import bpa_pkg::*;

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORDS-1:0]     row_valid_reg;
    logic [WORD_BITS-1:0] mem_q_reg;
    logic                 valid_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[cmd.wr_addr] <= wr_data;
        if (cmd.rd_en)
            mem_q_reg <= mem[cmd.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            valid_q_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
                row_valid_reg[cmd.wr_addr] <= 1'b1;
            if (cmd.rd_en)
                valid_q_reg <= row_valid_reg[cmd.rd_addr];
        end
    end

    // rows never written since reset read as all free
    assign rd_data = valid_q_reg ? mem_q_reg : '0;

endmodule
`default_nettype wire

// ===== rtl/bitmap_page_allocator.sv =====
// Top level of the bitmap page allocator: config registers and operation sequencer.
//
// First-fit page frame allocator over a map of MAX_PAGES used bits, held as
// 32-bit words in an internal memory. A request is taken when start is high
// and busy is low; busy then stays high until the result has been shown.
// The result (ok, address, free_count) is on the ports for exactly one cycle
// with done high, and the receiver must take it then: it cannot stall.
// Steps of each operation, from the accepting edge to the done cycle:
//   init  - one map word written per cycle, then done.
//   alloc - one map word read and checked per cycle through the single read
//           port, then the address step when a free page was found; a scan
//           that finds nothing goes straight to done.
//   free  - start address, index and read, check and write back; the check
//           is skipped when the index is out of range.
//   other codes - straight to done.
// No clearing pass runs after reset: each map row has a valid flag that
// reset clears, and an unwritten row reads as all free.
// Config writes are always taken (cfg_ready is tied high) and must only be
// issued while busy is low.
`default_nettype none
module bitmap_page_allocator (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   operation,
    input  wire logic [bpa_pkg::ADDR_W-1:0]   page_address,
    output logic                              done,
    output logic                              ok,
    output logic      [bpa_pkg::ADDR_W-1:0]   address,
    output logic      [bpa_pkg::CNT_W-1:0]    free_count,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [bpa_pkg::ADDR_W-1:0]   cfg_data
);
    import bpa_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE       = 8'b0000_0001,
        ST_INIT       = 8'b0000_0010,
        ST_SCAN       = 8'b0000_0100,
        ST_ALLOC_ADDR = 8'b0000_1000,
        ST_FREE_START = 8'b0001_0000,
        ST_FREE_IDX   = 8'b0010_0000,
        ST_FREE_CHK   = 8'b0100_0000,
        ST_DONE       = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [ADDR_W-1:0] base_reg;
    logic [CNT_W-1:0]  managed_reg, offset_reg, reserved_reg;

    // allocator state
    logic [CNT_W-1:0]  free_pages_reg, free_pages_next;

    // per-request working registers
    logic [CNT_W-1:0]   lim_reg, lim_next;
    logic [CNT_W-1:0]   res_reg, res_next;
    logic [ADDR_W-1:0]  aligned_reg, aligned_next;
    logic [ADDR_W-1:0]  start_reg, start_next;
    logic [ADDR_W-1:0]  req_addr_reg, req_addr_next;
    logic [WORD_AW-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               ok_reg, ok_next;
    logic [ADDR_W-1:0]  address_reg, address_next;

    map_cmd_t             map_cmd;
    logic [WORD_BITS-1:0] map_wr_data;
    logic [WORD_BITS-1:0] map_rd_data;

    // combinational helpers
    logic [CNT_W-1:0]     lim_now, res_now;
    logic [WORD_BITS-1:0] avail;
    logic [BIT_AW-1:0]    hit_pos;
    logic [CNT_W-1:0]     next_base;
    logic                 scan_last;
    logic [ADDR_W-1:0]    diff;
    logic [PIDX_W-1:0]    pidx;
    logic                 in_range;
    logic [PN_W-1:0]      page_num;

    bpa_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (map_cmd),
        .wr_data (map_wr_data),
        .rd_data (map_rd_data)
    );

    assign busy       = (state_reg != ST_IDLE);
    assign done       = (state_reg == ST_DONE);
    assign ok         = ok_reg;
    assign address    = address_reg;
    assign free_count = free_pages_reg;
    assign cfg_ready  = 1'b1;

    // managed count clamps to the map size, reserved count to the managed one
    assign lim_now = (managed_reg > MAX_CNT) ? MAX_CNT : managed_reg;
    assign res_now = (reserved_reg > lim_now) ? lim_now : reserved_reg;

    // scan: free bits of the current word that fall below the managed limit
    assign avail     = ~map_rd_data & prefix_mask(lim_reg, ptr_reg);
    assign hit_pos   = lowest_set(avail);
    assign next_base = CNT_W'({ptr_reg, {BIT_AW{1'b0}}}) + CNT_W'(WORD_BITS);
    assign scan_last = (ptr_reg == WORD_AW'(WORDS - 1)) || (next_base >= lim_reg);

    // free: address to page index relative to the first managed page
    assign diff     = req_addr_reg - start_reg;
    assign pidx     = diff[ADDR_W-1:PAGE_SHIFT];
    assign in_range = pidx < PIDX_W'(lim_reg);

    assign page_num = PN_W'(idx_reg) + PN_W'(offset_reg);

    always_comb
    begin
        state_next      = state_reg;
        free_pages_next = free_pages_reg;
        lim_next        = lim_reg;
        res_next        = res_reg;
        aligned_next    = aligned_reg;
        start_next      = start_reg;
        req_addr_next   = req_addr_reg;
        ptr_next        = ptr_reg;
        idx_next        = idx_reg;
        ok_next         = ok_reg;
        address_next    = address_reg;
        map_cmd         = '0;
        map_wr_data     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ok_next       = 1'b0;
                    address_next  = '0;
                    lim_next      = lim_now;
                    res_next      = res_now;
                    aligned_next  = align_up(base_reg);
                    req_addr_next = page_address;
                    ptr_next      = '0;
                    unique case (operation)
                        OP_INIT:
                        begin
                            free_pages_next = lim_now - res_now;
                            state_next      = ST_INIT;
                        end
                        OP_ALLOC:
                        begin
                            map_cmd.rd_en   = 1'b1;
                            map_cmd.rd_addr = '0;
                            state_next      = ST_SCAN;
                        end
                        OP_FREE:
                            state_next = ST_FREE_START;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end

            ST_INIT:
            begin
                map_cmd.wr_en   = 1'b1;
                map_cmd.wr_addr = ptr_reg;
                map_wr_data     = prefix_mask(res_reg, ptr_reg);
                if (ptr_reg == WORD_AW'(WORDS - 1))
                begin
                    ok_next    = 1'b1;
                    state_next = ST_DONE;
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end

            ST_SCAN:
            begin
                if (|avail)
                begin
                    map_cmd.wr_en   = 1'b1;
                    map_cmd.wr_addr = ptr_reg;
                    map_wr_data     = map_rd_data | (WORD_BITS'(1) << hit_pos);
                    idx_next        = {ptr_reg, hit_pos};
                    ok_next         = 1'b1;
                    if (free_pages_reg != '0)
                        free_pages_next = free_pages_reg - 1'b1;
                    state_next      = ST_ALLOC_ADDR;
                end
                else if (scan_last)
                    state_next = ST_DONE;
                else
                begin
                    // fetch the next word while this one is checked
                    map_cmd.rd_en   = 1'b1;
                    map_cmd.rd_addr = ptr_reg + 1'b1;
                    ptr_next        = ptr_reg + 1'b1;
                end
            end

            ST_ALLOC_ADDR:
            begin
                address_next = aligned_reg + (ADDR_W'(page_num) << PAGE_SHIFT);
                state_next   = ST_DONE;
            end

            ST_FREE_START:
            begin
                start_next = aligned_reg + (ADDR_W'(offset_reg) << PAGE_SHIFT);
                state_next = ST_FREE_IDX;
            end

            ST_FREE_IDX:
            begin
                if (in_range)
                begin
                    ok_next         = 1'b1;
                    idx_next        = pidx[IDX_W-1:0];
                    map_cmd.rd_en   = 1'b1;
                    map_cmd.rd_addr = pidx[IDX_W-1:BIT_AW];
                    state_next      = ST_FREE_CHK;
                end
                else
                    state_next = ST_DONE;
            end

            ST_FREE_CHK:
            begin
                // a page already free leaves map and count alone
                if (map_rd_data[idx_reg[BIT_AW-1:0]])
                begin
                    map_cmd.wr_en   = 1'b1;
                    map_cmd.wr_addr = idx_reg[IDX_W-1:BIT_AW];
                    map_wr_data     = map_rd_data &
                                      ~(WORD_BITS'(1) << idx_reg[BIT_AW-1:0]);
                    if (free_pages_reg != COUNT_MAX)
                        free_pages_next = free_pages_reg + 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
                state_next = ST_IDLE;

            default:
                state_next = ST_IDLE;
        endcase
    end

    // control state and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_pages_reg <= '0;
            base_reg       <= '0;
            managed_reg    <= MAX_CNT;
            offset_reg     <= '0;
            reserved_reg   <= '0;
            ok_reg         <= 1'b0;
            address_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            free_pages_reg <= free_pages_next;
            ok_reg         <= ok_next;
            address_reg    <= address_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_BASE:     base_reg     <= cfg_data;
                    CFG_MANAGED:  managed_reg  <= cfg_data[CNT_W-1:0];
                    CFG_OFFSET:   offset_reg   <= cfg_data[CNT_W-1:0];
                    CFG_RESERVED: reserved_reg <= cfg_data[CNT_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        lim_reg      <= lim_next;
        res_reg      <= res_next;
        aligned_reg  <= aligned_next;
        start_reg    <= start_next;
        req_addr_reg <= req_addr_next;
        ptr_reg      <= ptr_next;
        idx_reg      <= idx_next;
    end

endmodule
`default_nettype wire
